FILE: rtl/assert_macros.svh
// assertion macros for the chained hash set checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define CHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/chs_pkg.sv
// shared constants, types and codes of the chained hash set
package chs_pkg;

  localparam int MAX_BUCKETS = 64;
  localparam int POOL_NODES  = 1024;

  localparam int KEY_W   = 31;
  localparam int CFG_W   = 7;
  localparam int BKT_W   = $clog2(MAX_BUCKETS);
  localparam int MOD_W   = BKT_W + 1;
  localparam int NODE_W  = $clog2(POOL_NODES);
  localparam int CNT_W   = $clog2(POOL_NODES + 1);
  localparam int HT_W    = 2 * BKT_W;
  localparam int STEP_W  = $clog2(KEY_W + 1);
  localparam int NWORD_W = KEY_W + NODE_W + 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MODK,
    ST_TLOAD,
    ST_MODT,
    ST_LOOK,
    ST_HEAD,
    ST_WALK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic take;
    logic shift;
    logic load_t;
    logic head_rd;
    logic node_rd_head;
    logic node_rd_link;
    logic do_insert;
    logic set_found;
    logic set_full;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic last_step;
    logic is_search;
    logic pool_full;
    logic bkt_nonempty;
    logic key_match;
    logic link_valid;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/chs_ram.sv
// generic ram, one write port and one registered read port
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/chs_ctrl.sv
// controller state machine of the chained hash set
module chs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  chs_pkg::sts_t sts,
  output chs_pkg::cmd_t cmd
);

  chs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      chs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = chs_pkg::ST_MODK;
        end
      end
      chs_pkg::ST_MODK: begin
        cmd.shift = 1'b1;
        if (sts.last_step) begin
          state_nxt = chs_pkg::ST_TLOAD;
        end
      end
      chs_pkg::ST_TLOAD: begin
        cmd.load_t = 1'b1;
        state_nxt  = chs_pkg::ST_MODT;
      end
      chs_pkg::ST_MODT: begin
        cmd.shift = 1'b1;
        if (sts.last_step) begin
          state_nxt = chs_pkg::ST_LOOK;
        end
      end
      chs_pkg::ST_LOOK: begin
        if (!sts.is_search && sts.pool_full) begin
          cmd.set_full = 1'b1;
          state_nxt    = chs_pkg::ST_FIN;
        end else if (sts.is_search && !sts.bkt_nonempty) begin
          state_nxt = chs_pkg::ST_FIN;
        end else begin
          cmd.head_rd = 1'b1;
          state_nxt   = chs_pkg::ST_HEAD;
        end
      end
      chs_pkg::ST_HEAD: begin
        if (sts.is_search) begin
          cmd.node_rd_head = 1'b1;
          state_nxt        = chs_pkg::ST_WALK;
        end else begin
          cmd.do_insert = 1'b1;
          state_nxt     = chs_pkg::ST_FIN;
        end
      end
      chs_pkg::ST_WALK: begin
        priority if (sts.key_match) begin
          cmd.set_found = 1'b1;
          state_nxt     = chs_pkg::ST_FIN;
        end else if (!sts.link_valid) begin
          state_nxt = chs_pkg::ST_FIN;
        end else begin
          cmd.node_rd_link = 1'b1;
        end
      end
      chs_pkg::ST_FIN: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = chs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = chs_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/chs_datapath.sv
// datapath: hash unit, bucket and node stores, result register
module chs_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_func,
  input  logic [chs_pkg::KEY_W-1:0] in_key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_found,
  output logic                      out_status,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [chs_pkg::CFG_W-1:0] cfg_bucket_count,
  input  chs_pkg::cmd_t             cmd,
  output chs_pkg::sts_t             sts
);

  logic [chs_pkg::CFG_W-1:0]   cfg_r;
  logic [chs_pkg::MOD_W-1:0]   mod_m;
  logic                        func_r;
  logic [chs_pkg::KEY_W-1:0]   key_r;
  logic [chs_pkg::KEY_W-1:0]   shreg_r, shreg_nxt;
  logic [chs_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [chs_pkg::BKT_W-1:0]   rem_r, rem_nxt;
  logic [chs_pkg::MOD_W-1:0]   rem_ext;
  logic [chs_pkg::HT_W-1:0]    ht;
  logic [chs_pkg::MAX_BUCKETS-1:0] nonempty_r;
  logic [chs_pkg::CNT_W-1:0]   used_r;
  logic                        found_r, full_r;
  logic                        out_valid_r, out_found_r, out_status_r;
  logic [chs_pkg::NODE_W-1:0]  head_rdata;
  logic [chs_pkg::NWORD_W-1:0] node_rdata, node_wdata;
  logic [chs_pkg::NODE_W-1:0]  node_raddr;
  logic [chs_pkg::KEY_W-1:0]   node_key;
  logic [chs_pkg::NODE_W-1:0]  node_link;
  logic                        node_lv;

  assign cfg_ready = 1'b1;

  // bucket count clamped to 1..MAX_BUCKETS
  always_comb begin
    if (cfg_r == '0) begin
      mod_m = chs_pkg::MOD_W'(1);
    end else if (chs_pkg::MOD_W'(cfg_r) > chs_pkg::MOD_W'(chs_pkg::MAX_BUCKETS)) begin
      mod_m = chs_pkg::MOD_W'(chs_pkg::MAX_BUCKETS);
    end else begin
      mod_m = chs_pkg::MOD_W'(cfg_r);
    end
  end

  // restoring modulo step, one bit per cycle
  assign rem_ext = {rem_r, shreg_r[chs_pkg::KEY_W-1]};
  assign ht      = chs_pkg::HT_W'(rem_r) * chs_pkg::HT_W'(rem_r) + chs_pkg::HT_W'(rem_r)
                 + chs_pkg::HT_W'(1);

  always_comb begin
    shreg_nxt = shreg_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    if (cmd.take) begin
      shreg_nxt = in_key;
      cnt_nxt   = chs_pkg::STEP_W'(chs_pkg::KEY_W);
      rem_nxt   = '0;
    end else if (cmd.load_t) begin
      shreg_nxt = {ht, (chs_pkg::KEY_W - chs_pkg::HT_W)'(0)};
      cnt_nxt   = chs_pkg::STEP_W'(chs_pkg::HT_W);
      rem_nxt   = '0;
    end else if (cmd.shift) begin
      shreg_nxt = shreg_r << 1;
      cnt_nxt   = cnt_r - 1'b1;
      if (rem_ext >= mod_m) begin
        rem_nxt = chs_pkg::BKT_W'(rem_ext - mod_m);
      end else begin
        rem_nxt = chs_pkg::BKT_W'(rem_ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    if (cmd.take) begin
      func_r <= in_func;
      key_r  <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= chs_pkg::CFG_RESET;
      nonempty_r   <= '0;
      used_r       <= '0;
      found_r      <= 1'b0;
      full_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      out_found_r  <= 1'b0;
      out_status_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_bucket_count;
      end
      if (cmd.do_insert) begin
        nonempty_r[rem_r] <= 1'b1;
        used_r            <= used_r + 1'b1;
      end
      if (cmd.take) begin
        found_r <= 1'b0;
        full_r  <= 1'b0;
      end else begin
        if (cmd.set_found) begin
          found_r <= 1'b1;
        end
        if (cmd.set_full) begin
          full_r <= 1'b1;
        end
      end
      if (cmd.res_load) begin
        out_valid_r  <= 1'b1;
        out_found_r  <= found_r;
        out_status_r <= full_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  chs_ram #(
    .WIDTH (chs_pkg::NODE_W),
    .DEPTH (chs_pkg::MAX_BUCKETS)
  ) u_head_ram (
    .clk   (clk),
    .we    (cmd.do_insert),
    .waddr (rem_r),
    .wdata (used_r[chs_pkg::NODE_W-1:0]),
    .re    (cmd.head_rd),
    .raddr (rem_r),
    .rdata (head_rdata)
  );

  assign node_wdata = {key_r, head_rdata, nonempty_r[rem_r]};
  assign node_raddr = cmd.node_rd_link ? node_link : head_rdata;

  chs_ram #(
    .WIDTH (chs_pkg::NWORD_W),
    .DEPTH (chs_pkg::POOL_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (cmd.do_insert),
    .waddr (used_r[chs_pkg::NODE_W-1:0]),
    .wdata (node_wdata),
    .re    (cmd.node_rd_head | cmd.node_rd_link),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  assign node_key  = node_rdata[chs_pkg::NWORD_W-1 -: chs_pkg::KEY_W];
  assign node_link = node_rdata[chs_pkg::NODE_W:1];
  assign node_lv   = node_rdata[0];

  assign sts.last_step    = (cnt_r == chs_pkg::STEP_W'(1));
  assign sts.is_search    = (func_r == chs_pkg::FUNC_SEARCH);
  assign sts.pool_full    = (used_r == chs_pkg::CNT_W'(chs_pkg::POOL_NODES));
  assign sts.bkt_nonempty = nonempty_r[rem_r];
  assign sts.key_match    = (node_key == key_r);
  assign sts.link_valid   = node_lv;
  assign sts.out_free     = !out_valid_r || !out_stall;

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_status = out_status_r;

endmodule

FILE: rtl/chained_hash_set_unit.sv
// top level of the chained hash set; bit-serial hash modulo, 31 key bits then 12 bits
// flow: key modulo, hash load, hash modulo and bucket lookup; a refused insert or a search of
//   an empty bucket ends there, else the head is read, then an insert or a walk of the chain
// throughput: one word at a time, the next accepted the cycle after its result is registered;
//   a stalled result holds the unit until the previous word leaves
// reset: synchronous active low; bucket flags, node count, result valid clear, bucket count 64
module chained_hash_set_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_func,
  input  logic [chs_pkg::KEY_W-1:0] in_key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_found,
  output logic                      out_status,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [chs_pkg::CFG_W-1:0] cfg_bucket_count
);

  chs_pkg::cmd_t cmd;
  chs_pkg::sts_t sts;

  chs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  chs_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_func          (in_func),
    .in_key           (in_key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_bucket_count (cfg_bucket_count),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

FILE: rtl/chs_checker.sv
// port checker of the chained hash set and its bind
`include "assert_macros.svh"

module chs_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_found,
  input logic                      out_status
);

  `CHS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_found) && $stable(out_status))
  `CHS_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  `CHS_ASSERT_NOW(a_found_or_full, out_valid, !(out_found && out_status))
  `CHS_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall, !out_valid || $past(out_valid))

endmodule

bind chained_hash_set_unit chs_checker u_chs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_found  (out_found),
  .out_status (out_status)
);
